[design/adet_pkg.sv]
// shared widths, codes and transaction types of the ack delay ewma tracker
// no dependencies; imported by every module of the block
package adet_pkg;

	localparam int TIME_BITS  = 32;
	localparam int FRAC_BITS  = 16;
	localparam int FLOW_BITS  = 16;
	localparam int SEQ_BITS   = 32;
	localparam int RATE_BITS  = 24;
	localparam int DIVD_BITS  = TIME_BITS + FRAC_BITS;
	localparam int VAL_BITS   = (DIVD_BITS > 64) ? 64 : DIVD_BITS;
	localparam int SMP_BITS   = TIME_BITS + RATE_BITS;
	localparam int SUM_BITS   = SMP_BITS + 2;
	localparam int EWMA_FAST_SHIFT = 3;
	localparam int EWMA_SLOW_SHIFT = 8;

	localparam int IN_DATA_BITS  = FLOW_BITS + SEQ_BITS + 3 * TIME_BITS;
	localparam int OUT_DATA_BITS = 5 * VAL_BITS;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam int DIV_STEPS   = DIVD_BITS;
	localparam int DCNT_BITS   = $clog2(DIV_STEPS);

	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = RATE_BITS;

	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
	localparam cfg_index_t REG_OWN_FLOW    = 1'd0;
	localparam cfg_index_t REG_RATE_FACTOR = 1'd1;

	localparam logic [VAL_BITS-1:0] VAL_MAX = '1;

	typedef struct packed {
		logic                 matched;
		logic [SEQ_BITS-1:0]  seq;
		logic [TIME_BITS-1:0] sent;
		logic [TIME_BITS-1:0] recv;
		logic [TIME_BITS-1:0] stamp;
	} item_t;

	typedef struct packed {
		logic [VAL_BITS-1:0] rtt;
		logic [VAL_BITS-1:0] ratio;
		logic [VAL_BITS-1:0] slow;
		logic [VAL_BITS-1:0] recv;
		logic [VAL_BITS-1:0] send;
	} result_t;

endpackage

[design/adet_front.sv]
// front end: input register, flow classification and push into the queue
// depends on adet_pkg
module adet_front import adet_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [IN_DATA_BITS-1:0] s_tdata,
	input  logic [FLOW_BITS-1:0]    own_flow,
	input  logic                    q_full,
	output logic                    q_push,
	output item_t                   q_item
);

	logic  valid_s1;
	item_t item_s1;
	logic  [FLOW_BITS-1:0] flow;

	assign flow     = s_tdata[FLOW_BITS-1:0];
	assign q_push   = valid_s1 && !q_full;
	assign q_item   = item_s1;
	assign s_tready = !valid_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// fields from the lowest bit up: flow, seq, sent, recv, stamp
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.matched <= (flow == own_flow);
			item_s1.seq     <= s_tdata[FLOW_BITS +: SEQ_BITS];
			item_s1.sent    <= s_tdata[FLOW_BITS + SEQ_BITS +: TIME_BITS];
			item_s1.recv    <= s_tdata[FLOW_BITS + SEQ_BITS + TIME_BITS +: TIME_BITS];
			item_s1.stamp   <= s_tdata[FLOW_BITS + SEQ_BITS + 2 * TIME_BITS +: TIME_BITS];
		end
	end

endmodule

[design/adet_queue.sv]
// short register queue between the front end and the back end
// depends on adet_pkg
module adet_queue import adet_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  empty
);

	item_t                entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign full     = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[design/adet_div.sv]
// restoring divider, one quotient bit per cycle, for the rtt ratio
// depends on adet_pkg
module adet_div import adet_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIVD_BITS-1:0] dividend,
	input  logic [TIME_BITS-1:0] divisor,
	output logic                 done,
	output logic [DIVD_BITS-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DCNT_BITS-1:0] cnt_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [DIVD_BITS-1:0] quo_q;
	logic [TIME_BITS-1:0] dsor_q;
	logic [TIME_BITS:0]   rem_sh;
	logic                 fits;

	assign rem_sh   = {rem_q, quo_q[DIVD_BITS-1]};
	assign fits     = (rem_sh >= {1'b0, dsor_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_BITS'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits shift out of the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dsor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? TIME_BITS'(rem_sh - {1'b0, dsor_q}) : rem_sh[TIME_BITS-1:0];
			quo_q <= {quo_q[DIVD_BITS-2:0], fits};
		end
	end

endmodule

[design/adet_back.sv]
// back end: tracker state, update sequencer, shared multiplier and result register
// depends on adet_pkg and adet_div
module adet_back import adet_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [RATE_BITS-1:0]     rate_factor,
	input  logic                     q_empty,
	input  item_t                    q_item,
	output logic                     q_pop,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	output logic                     m_matched
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CALC  = 7'b0000010,
		ST_MUL_S = 7'b0000100,
		ST_MUL_R = 7'b0001000,
		ST_UPD   = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;
	item_t  cur_q;

	logic [TIME_BITS-1:0] prev_sent_q, prev_recv_q, prev_stamp_q, lowest_q;
	logic [SEQ_BITS-1:0]  top_ack_q;
	logic [VAL_BITS-1:0]  rtt_avg_q, send_avg_q, recv_avg_q, slow_avg_q, ratio_q;

	logic [TIME_BITS-1:0] rtt_q, send_int_q, recv_int_q;
	logic                 inord_q;
	logic [SMP_BITS-1:0]  s_smp_q, r_smp_q;

	logic                 out_valid_q;
	logic                 out_match_q;
	result_t              out_q;

	logic [TIME_BITS-1:0] rtt, send_int, recv_int;
	logic                 first, inord;
	logic [TIME_BITS-1:0] mul_op;
	logic [SMP_BITS-1:0]  product;
	logic [DIVD_BITS-1:0] rtt_fixed;
	logic                 div_start, div_done;
	logic [DIVD_BITS-1:0] div_quo;
	logic                 out_free;

	function automatic logic [VAL_BITS-1:0] ewma(input logic [VAL_BITS-1:0] avg,
			input logic [SMP_BITS-1:0] smp, input logic slow);
		logic [SUM_BITS-1:0] avg_w;
		logic [SUM_BITS-1:0] sum;
		logic [SUM_BITS-1:0] shr;
		avg_w = SUM_BITS'(avg);
		// avg * (2^k - 1) as a shift and subtract
		if (slow) begin
			sum = (avg_w << EWMA_SLOW_SHIFT) - avg_w + SUM_BITS'(smp);
			shr = sum >> EWMA_SLOW_SHIFT;
		end else begin
			sum = (avg_w << EWMA_FAST_SHIFT) - avg_w + SUM_BITS'(smp);
			shr = sum >> EWMA_FAST_SHIFT;
		end
		return (shr > SUM_BITS'(VAL_MAX)) ? VAL_MAX : shr[VAL_BITS-1:0];
	endfunction

	assign rtt      = (cur_q.recv >= cur_q.sent) ? cur_q.recv - cur_q.sent : '0;
	assign send_int = (cur_q.sent >= prev_sent_q) ? cur_q.sent - prev_sent_q : '0;
	assign recv_int = (cur_q.stamp >= prev_stamp_q) ? cur_q.stamp - prev_stamp_q : '0;
	assign first    = (prev_sent_q == '0) || (prev_recv_q == '0);
	assign inord    = ((cur_q.seq - SEQ_BITS'(1)) == top_ack_q);

	assign mul_op    = (state_q == ST_MUL_S) ? send_int_q : recv_int_q;
	assign product   = SMP_BITS'(mul_op) * SMP_BITS'(rate_factor);
	assign rtt_fixed = {rtt_q, {FRAC_BITS{1'b0}}};

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign div_start = (state_q == ST_UPD) && (lowest_q != '0);
	assign out_free  = !out_valid_q || m_tready;

	adet_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rtt_fixed),
		.divisor  (lowest_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_sent_q  <= '0;
			prev_recv_q  <= '0;
			prev_stamp_q <= '0;
			lowest_q     <= '0;
			top_ack_q    <= '0;
			rtt_avg_q    <= '0;
			send_avg_q   <= '0;
			recv_avg_q   <= '0;
			slow_avg_q   <= '0;
			ratio_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (!cur_q.matched) begin
						state_q <= ST_EMIT;
					end else begin
						if (cur_q.seq > top_ack_q) begin
							top_ack_q <= cur_q.seq;
						end
						if (first) begin
							prev_sent_q  <= cur_q.sent;
							prev_recv_q  <= cur_q.recv;
							prev_stamp_q <= cur_q.stamp;
							lowest_q     <= rtt;
							rtt_avg_q    <= VAL_BITS'({rtt, {FRAC_BITS{1'b0}}});
							state_q      <= ST_EMIT;
						end else begin
							if (inord) begin
								prev_sent_q  <= cur_q.sent;
								prev_recv_q  <= cur_q.recv;
								prev_stamp_q <= cur_q.stamp;
							end
							if (rtt < lowest_q) begin
								lowest_q <= rtt;
							end
							state_q <= ST_MUL_S;
						end
					end
				end
				ST_MUL_S: state_q <= ST_MUL_R;
				ST_MUL_R: state_q <= ST_UPD;
				ST_UPD: begin
					if (inord_q) begin
						send_avg_q <= ewma(send_avg_q, s_smp_q, 1'b0);
						recv_avg_q <= ewma(recv_avg_q, r_smp_q, 1'b0);
						slow_avg_q <= ewma(slow_avg_q, r_smp_q, 1'b1);
					end
					rtt_avg_q <= ewma(rtt_avg_q, SMP_BITS'(rtt_fixed), 1'b0);
					// zero minimum rtt saturates the ratio
					if (lowest_q == '0) begin
						ratio_q <= VAL_MAX;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						ratio_q <= VAL_BITS'(div_quo);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (state_q == ST_CALC) begin
			rtt_q      <= rtt;
			send_int_q <= send_int;
			recv_int_q <= recv_int;
			inord_q    <= inord;
		end
		if (state_q == ST_MUL_S) begin
			s_smp_q <= product;
		end
		if (state_q == ST_MUL_R) begin
			r_smp_q <= product;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_match_q <= cur_q.matched;
			out_q.send  <= send_avg_q;
			out_q.recv  <= recv_avg_q;
			out_q.slow  <= slow_avg_q;
			out_q.ratio <= ratio_q;
			out_q.rtt   <= rtt_avg_q;
		end
	end

	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;
	assign m_matched = out_match_q;

endmodule

[design/ack_delay_ewma_tracker.sv]
// top level of the ack delay ewma tracker: config registers, front end, queue, back end
// depends on adet_pkg, adet_front, adet_queue, adet_back
//
// One acknowledgment per input transaction, one result transaction per acknowledgment,
// in order. Acks of the configured flow update the minimum and smoothed rtt and, after the
// first, the rtt ratio and (if in order) the send, receive and slow receive interval ewmas;
// other flows report the current state with the matched flag low. The back end handles one
// ack at a time: a tracked ack passes pop, compute, two products on the shared 32x24
// multiplier, ewma update, the one-bit-per-cycle ratio divider and result load; the first
// ack of the flow and acks of other flows skip multiplier and divider, a zero minimum rtt
// skips the divider. An input register and a two-entry queue let the input side run ahead
// of the back end, and a result register lets the back end finish while the previous result
// waits. Configuration is written only while idle: a user rule, not enforced by the block.
module ack_delay_ewma_tracker import adet_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,   // ack_flow, seq_number, sent_time, recv_time, receiver_stamp
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,   // send_ewma, recv_ewma, slow_recv_ewma, ratio_out, rtt_smoothed
	output logic [0:0]               m_tuser,   // matched
	input  logic                     cfg_wen,
	input  cfg_index_t               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	logic [FLOW_BITS-1:0] own_flow_q;
	logic [RATE_BITS-1:0] rate_factor_q;

	logic  q_push, q_pop, q_full, q_empty;
	item_t push_item, pop_item;
	logic  matched;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_flow_q    <= '0;
			rate_factor_q <= RATE_BITS'(1) << FRAC_BITS;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_OWN_FLOW:    own_flow_q    <= cfg_data[FLOW_BITS-1:0];
				REG_RATE_FACTOR: rate_factor_q <= cfg_data[RATE_BITS-1:0];
				default: ;
			endcase
		end
	end

	adet_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.own_flow (own_flow_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	adet_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	adet_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rate_factor (rate_factor_q),
		.q_empty     (q_empty),
		.q_item      (pop_item),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_matched   (matched)
	);

	assign m_tuser = matched;

endmodule

[design/adet_checker.sv]
// port-level checks of the ack delay ewma tracker, bound to the top level
// depends on adet_pkg and ack_delay_ewma_tracker
module adet_checker import adet_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [OUT_DATA_BITS-1:0] m_tdata,
	input logic [0:0]               m_tuser
);

	logic [OUT_DATA_BITS-1:0] last_q;
	logic [VAL_BITS-1:0]      ratio;

	assign ratio = m_tdata[3 * VAL_BITS +: VAL_BITS];

	// state reported by the last result transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (m_tvalid && m_tready) begin
			last_q <= m_tdata;
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result valid dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// an ack of another flow leaves the state as the previous result showed it
	a_other_flow_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == last_q)
		else $error("ack of another flow changed the state");

	// rtt never drops below the minimum rtt, so the ratio is zero or at least one
	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ratio == '0 || ratio[VAL_BITS-1:FRAC_BITS] != '0)
		else $error("rtt ratio below one");

endmodule

bind ack_delay_ewma_tracker adet_checker u_adet_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
